[rtl/core/dvr_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and item codes for the distance-vector relax block.
// No dependencies; distance_vector_relax in rtl/core refers to it by scope.
package dvr_pkg;

  // Defaults for the top-level parameters
  localparam int NODES_DEF     = 8;
  localparam int COST_BITS_DEF = 16;

  // Fixed port field widths
  localparam int KIND_W = 2;
  localparam int NODE_W = 3;
  localparam int VAL_W  = 16;
  localparam int HOP_W  = 3;
  localparam int CNT_W  = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_LINK  = 2'd0,
    KIND_ROUTE = 2'd1,
    KIND_XCHG  = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

endpackage

[rtl/core/dvr_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dvr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old word when the same address is written in that cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/dvr_relax_unit.sv]
`timescale 1ns / 1ps
// Relaxation datapath: saturating add of sender cost and link cost, compare
// against the receiver's current cost. Depends on nothing but its parameter.
module dvr_relax_unit #(
  parameter int COST_BITS = 16
) (
  input  logic [COST_BITS-1:0] route_n_i,
  input  logic [COST_BITS-1:0] link_i,
  input  logic [COST_BITS-1:0] route_m_i,
  output logic [COST_BITS-1:0] cand_o,
  output logic                 better_o
);

  localparam logic [COST_BITS-1:0] INF = {COST_BITS{1'b1}};

  logic [COST_BITS:0] sum;

  // an infinite operand always lands at or above INF and saturates
  assign sum      = {1'b0, route_n_i} + {1'b0, link_i};
  assign cand_o   = (sum >= {1'b0, INF}) ? INF : sum[COST_BITS-1:0];
  assign better_o = cand_o < route_m_i;

endmodule

[rtl/core/distance_vector_relax.sv]
`timescale 1ns / 1ps
// Top level of the distance-vector relax block: control sequencer, link and
// route memories. Uses dvr_pkg, dvr_ram and dvr_relax_unit.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------------
//   in      | to block  | in_valid_i/in_stall_o  | kind, node_a, node_b, dest_node,
//           |           |                        | cost_value, hop_value
//   out     | from block| out_valid_o/out_stall_i| route_cost, route_hop, updated_count
//
// Loads finish in S_DONE, reads pass S_READ and S_RDATA, valid exchanges S_LINK
// and S_SWEEP; the sweep reads, relaxes and writes back one destination per cycle
// through the route memory. After reset a clearing pass fills all tables with
// unreachable costs; in_stall_o is high until it ends. One item is in work at
// a time; a finished beat waits in the output register and the next item is
// taken meanwhile.
module distance_vector_relax #(
  parameter int NODES     = dvr_pkg::NODES_DEF,
  parameter int COST_BITS = dvr_pkg::COST_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [dvr_pkg::KIND_W-1:0] kind_i,
  input  logic [dvr_pkg::NODE_W-1:0] node_a_i,
  input  logic [dvr_pkg::NODE_W-1:0] node_b_i,
  input  logic [dvr_pkg::NODE_W-1:0] dest_node_i,
  input  logic [dvr_pkg::VAL_W-1:0]  cost_value_i,
  input  logic [dvr_pkg::HOP_W-1:0]  hop_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [dvr_pkg::VAL_W-1:0]  route_cost_o,
  output logic [dvr_pkg::HOP_W-1:0]  route_hop_o,
  output logic [dvr_pkg::CNT_W-1:0]  updated_count_o
);

  localparam int NW    = $clog2(NODES);
  localparam int DEPTH = NODES * NODES;
  localparam int AW    = $clog2(DEPTH);
  localparam int HW    = dvr_pkg::HOP_W;
  localparam int RW    = COST_BITS + HW;

  localparam logic [COST_BITS-1:0] INF       = {COST_BITS{1'b1}};
  localparam logic [AW-1:0]        CLR_LAST  = AW'(DEPTH - 1);
  localparam logic [NW-1:0]        NODE_LAST = NW'(NODES - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_LINK  = 7'b0000100,
    S_SWEEP = 7'b0001000,
    S_READ  = 7'b0010000,
    S_RDATA = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  function automatic logic node_ok(logic [dvr_pkg::NODE_W-1:0] v);
    return 32'(v) < NODES;
  endfunction

  function automatic logic [AW-1:0] cell_addr(logic [NW-1:0] row, logic [NW-1:0] col);
    return AW'(32'(row) * NODES + 32'(col));
  endfunction

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [NW-1:0] x_q, x_d;
  logic          out_valid_q, out_valid_d;
  logic          accept;
  logic          out_load;

  dvr_pkg::kind_e                kind_q;
  logic [dvr_pkg::NODE_W-1:0]    a_q, b_q, d_q;
  logic [COST_BITS-1:0]          res_cost_q;
  logic [HW-1:0]                 res_hop_q;
  logic [dvr_pkg::CNT_W-1:0]     res_cnt_q;
  logic [dvr_pkg::VAL_W-1:0]     route_cost_q;
  logic [HW-1:0]                 route_hop_q;
  logic [dvr_pkg::CNT_W-1:0]     updated_count_q;

  logic [COST_BITS-1:0] cost_in;
  logic [NW-1:0]        a_idx, b_idx, d_idx, rd_x;

  logic                 link_we;
  logic [AW-1:0]        link_waddr, link_raddr;
  logic [COST_BITS-1:0] link_wdata, link_rdata;

  logic                 rt_we;
  logic [AW-1:0]        rt_waddr, rtm_raddr, rtn_raddr;
  logic [RW-1:0]        rt_wdata, rtm_rdata, rtn_rdata;

  logic [COST_BITS-1:0] cand;
  logic                 better;

  assign cost_in = COST_BITS'(cost_value_i);
  assign a_idx   = NW'(a_q);
  assign b_idx   = NW'(b_q);
  assign d_idx   = NW'(d_q);
  assign accept  = (state_q == S_IDLE) && in_valid_i;

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign route_cost_o    = route_cost_q;
  assign route_hop_o     = route_hop_q;
  assign updated_count_o = updated_count_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    x_d         = x_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_load    = 1'b0;
    case (state_q)
      S_CLEAR: begin
        clr_d = AW'(32'(clr_q) + 1);
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            dvr_pkg::KIND_XCHG: begin
              state_d = (node_ok(node_a_i) && node_ok(node_b_i)) ? S_LINK : S_DONE;
            end
            dvr_pkg::KIND_READ: state_d = S_READ;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_LINK: begin
        x_d     = '0;
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        x_d = NW'(32'(x_q) + 1);
        if (x_q == NODE_LAST) begin
          state_d = S_DONE;
        end
      end
      S_READ:  state_d = S_RDATA;
      S_RDATA: state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      x_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      x_q         <= x_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Item and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= dvr_pkg::kind_e'(kind_i);
      a_q    <= node_a_i;
      b_q    <= node_b_i;
      d_q    <= dest_node_i;
      case (kind_i)
        dvr_pkg::KIND_LINK: begin
          res_cost_q <= cost_in;
          res_hop_q  <= '0;
        end
        dvr_pkg::KIND_ROUTE: begin
          res_cost_q <= cost_in;
          res_hop_q  <= hop_value_i;
        end
        default: begin
          res_cost_q <= '0;
          res_hop_q  <= '0;
        end
      endcase
      res_cnt_q <= '0;
    end
    // count improved destinations, hold at the top code
    if (state_q == S_SWEEP && better && res_cnt_q != dvr_pkg::CNT_MAX) begin
      res_cnt_q <= res_cnt_q + 1'b1;
    end
    if (state_q == S_RDATA && kind_q == dvr_pkg::KIND_READ) begin
      if (node_ok(a_q) && node_ok(d_q)) begin
        res_cost_q <= rtm_rdata[RW-1:HW];
        res_hop_q  <= rtm_rdata[HW-1:0];
      end else begin
        res_cost_q <= INF;
        res_hop_q  <= '0;
      end
    end
    if (out_load) begin
      route_cost_q    <= dvr_pkg::VAL_W'(res_cost_q);
      route_hop_q     <= res_hop_q;
      updated_count_q <= res_cnt_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Memory ports
  // ---------------------------------------------------------------------------
  // The sweep writes entry x while it reads entry x+1, so a write never meets
  // a read of the same entry and no forwarding is needed.
  assign rd_x       = (state_q == S_SWEEP) ? NW'(32'(x_q) + 1) : '0;
  assign link_raddr = cell_addr(a_idx, b_idx);
  assign rtn_raddr  = cell_addr(b_idx, rd_x);
  assign rtm_raddr  = (state_q == S_READ) ? cell_addr(a_idx, d_idx) : cell_addr(a_idx, rd_x);

  always_comb begin
    link_we    = 1'b0;
    link_waddr = cell_addr(NW'(node_a_i), NW'(node_b_i));
    link_wdata = cost_in;
    rt_we      = 1'b0;
    rt_waddr   = cell_addr(a_idx, x_q);
    rt_wdata   = {cand, b_q};
    case (state_q)
      S_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = clr_q;
        link_wdata = INF;
        rt_we      = 1'b1;
        rt_waddr   = clr_q;
        rt_wdata   = {INF, {HW{1'b0}}};
      end
      S_IDLE: begin
        link_we  = accept && (kind_i == dvr_pkg::KIND_LINK) &&
                   node_ok(node_a_i) && node_ok(node_b_i);
        rt_we    = accept && (kind_i == dvr_pkg::KIND_ROUTE) &&
                   node_ok(node_a_i) && node_ok(dest_node_i);
        rt_waddr = cell_addr(NW'(node_a_i), NW'(dest_node_i));
        rt_wdata = {cost_in, hop_value_i};
      end
      S_SWEEP: rt_we = better;
      default: ;
    endcase
  end

  dvr_ram #(
    .WIDTH (COST_BITS),
    .DEPTH (DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  // Route table kept in two identical copies: one read port for the
  // receiving row, one for the sending row.
  dvr_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_route_m_ram (
    .clk_i   (clk_i),
    .we_i    (rt_we),
    .waddr_i (rt_waddr),
    .wdata_i (rt_wdata),
    .raddr_i (rtm_raddr),
    .rdata_o (rtm_rdata)
  );

  dvr_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_route_n_ram (
    .clk_i   (clk_i),
    .we_i    (rt_we),
    .waddr_i (rt_waddr),
    .wdata_i (rt_wdata),
    .raddr_i (rtn_raddr),
    .rdata_o (rtn_rdata)
  );

  dvr_relax_unit #(
    .COST_BITS (COST_BITS)
  ) u_relax (
    .route_n_i (rtn_rdata[RW-1:HW]),
    .link_i    (link_rdata),
    .route_m_i (rtm_rdata[RW-1:HW]),
    .cand_o    (cand),
    .better_o  (better)
  );

endmodule

[verif/dvr_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for distance_vector_relax: predicts the route beat that each accepted
// input beat causes and compares it with the beat the block returns.
// Depends on dvr_pkg for field widths and item kinds.
module dvr_checker #(
  parameter int NODES     = dvr_pkg::NODES_DEF,
  parameter int COST_BITS = dvr_pkg::COST_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [dvr_pkg::KIND_W-1:0] kind_i,
  input  logic [dvr_pkg::NODE_W-1:0] node_a_i,
  input  logic [dvr_pkg::NODE_W-1:0] node_b_i,
  input  logic [dvr_pkg::NODE_W-1:0] dest_node_i,
  input  logic [dvr_pkg::VAL_W-1:0]  cost_value_i,
  input  logic [dvr_pkg::HOP_W-1:0]  hop_value_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [dvr_pkg::VAL_W-1:0]  route_cost_i,
  input  logic [dvr_pkg::HOP_W-1:0]  route_hop_i,
  input  logic [dvr_pkg::CNT_W-1:0]  updated_count_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int CELLS = NODES * NODES;
  localparam logic [COST_BITS-1:0] COST_INF = '1;

  typedef struct packed {
    logic [dvr_pkg::VAL_W-1:0] cost;
    logic [dvr_pkg::HOP_W-1:0] hop;
    logic [dvr_pkg::CNT_W-1:0] count;
  } route_beat_t;

  logic [COST_BITS-1:0]         link_tbl  [CELLS];
  logic [COST_BITS-1:0]         route_tbl [CELLS];
  logic [dvr_pkg::HOP_W-1:0]    hop_tbl   [CELLS];
  route_beat_t                  expected_beats [$];

  function automatic bit node_ok(logic [dvr_pkg::NODE_W-1:0] v);
    return int'(v) < NODES;
  endfunction

  function automatic int cell_of(int row, int col);
    return row * NODES + col;
  endfunction

  function automatic logic [COST_BITS-1:0] sat_sum(logic [COST_BITS-1:0] a,
                                                    logic [COST_BITS-1:0] b);
    logic [COST_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, COST_INF}) return COST_INF;
    return s[COST_BITS-1:0];
  endfunction

  // Apply one item to the table copies and return the beat it must produce.
  function automatic route_beat_t relax_item(dvr_pkg::kind_e kind,
                                             logic [dvr_pkg::NODE_W-1:0] a,
                                             logic [dvr_pkg::NODE_W-1:0] b,
                                             logic [dvr_pkg::NODE_W-1:0] d,
                                             logic [dvr_pkg::VAL_W-1:0] cost_in,
                                             logic [dvr_pkg::HOP_W-1:0] hop);
    route_beat_t beat;
    logic [COST_BITS-1:0] cost;
    logic [COST_BITS-1:0] lk;
    logic [COST_BITS-1:0] cand;
    beat = '0;
    cost = COST_BITS'(cost_in);
    case (kind)
      dvr_pkg::KIND_LINK: begin
        if (node_ok(a) && node_ok(b)) link_tbl[cell_of(int'(a), int'(b))] = cost;
        beat.cost = dvr_pkg::VAL_W'(cost);
      end
      dvr_pkg::KIND_ROUTE: begin
        if (node_ok(a) && node_ok(d)) begin
          route_tbl[cell_of(int'(a), int'(d))] = cost;
          hop_tbl[cell_of(int'(a), int'(d))]   = hop;
        end
        beat.cost = dvr_pkg::VAL_W'(cost);
        beat.hop  = hop;
      end
      dvr_pkg::KIND_XCHG: begin
        if (node_ok(a) && node_ok(b)) begin
          lk = link_tbl[cell_of(int'(a), int'(b))];
          for (int x = 0; x < NODES; x++) begin
            cand = sat_sum(route_tbl[cell_of(int'(b), x)], lk);
            if (cand < route_tbl[cell_of(int'(a), x)]) begin
              route_tbl[cell_of(int'(a), x)] = cand;
              hop_tbl[cell_of(int'(a), x)]   = b;
              if (beat.count != dvr_pkg::CNT_MAX) beat.count++;
            end
          end
        end
      end
      default: begin
        if (node_ok(a) && node_ok(d)) begin
          beat.cost = dvr_pkg::VAL_W'(route_tbl[cell_of(int'(a), int'(d))]);
          beat.hop  = hop_tbl[cell_of(int'(a), int'(d))];
        end else begin
          beat.cost = dvr_pkg::VAL_W'(COST_INF);
        end
      end
    endcase
    return beat;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    route_beat_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CELLS; i++) begin
        link_tbl[i]  = COST_INF;
        route_tbl[i] = COST_INF;
        hop_tbl[i]   = '0;
      end
      expected_beats.delete();
      fail_count_o = 0;
    end else begin
      // Retire the output beat first so a spurious one is never masked.
      if (out_valid_i && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat, cost %0h hop %0h count %0h",
                   $time, route_cost_i, route_hop_i, updated_count_i);
          fail_count_o++;
        end else begin
          want = expected_beats.pop_front();
          check_field("route_cost", 32'(want.cost), 32'(route_cost_i));
          check_field("route_hop", 32'(want.hop), 32'(route_hop_i));
          check_field("updated_count", 32'(want.count), 32'(updated_count_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_beats.push_back(relax_item(dvr_pkg::kind_e'(kind_i), node_a_i, node_b_i,
                                            dest_node_i, cost_value_i, hop_value_i));
      end
    end
    pending_o = expected_beats.size();
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Top of the distance_vector_relax regression: clock, reset, directed and random
// stimulus, output stalling and the verdict. Uses dvr_pkg and dvr_checker.
module tb_top;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int ITEM_TARGET  = 1950;
  localparam int PHASE_ITEMS  = 240;
  localparam int DRAIN_CYCLES = 40;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid;
  logic                       in_stall;
  logic [dvr_pkg::KIND_W-1:0] kind;
  logic [dvr_pkg::NODE_W-1:0] node_a;
  logic [dvr_pkg::NODE_W-1:0] node_b;
  logic [dvr_pkg::NODE_W-1:0] dest_node;
  logic [dvr_pkg::VAL_W-1:0]  cost_value;
  logic [dvr_pkg::HOP_W-1:0]  hop_value;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [dvr_pkg::VAL_W-1:0]  route_cost;
  logic [dvr_pkg::HOP_W-1:0]  route_hop;
  logic [dvr_pkg::CNT_W-1:0]  updated_count;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  distance_vector_relax i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .node_a_i       (node_a),
    .node_b_i       (node_b),
    .dest_node_i    (dest_node),
    .cost_value_i   (cost_value),
    .hop_value_i    (hop_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .route_cost_o   (route_cost),
    .route_hop_o    (route_hop),
    .updated_count_o(updated_count)
  );

  dvr_checker i_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .kind_i         (kind),
    .node_a_i       (node_a),
    .node_b_i       (node_b),
    .dest_node_i    (dest_node),
    .cost_value_i   (cost_value),
    .hop_value_i    (hop_value),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .route_cost_i   (route_cost),
    .route_hop_i    (route_hop),
    .updated_count_i(updated_count),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("distance_vector_relax regression: fail");
      $finish;
    end
  end

  // Costs biased toward zero, small values, all ones and near overflow.
  function automatic logic [dvr_pkg::VAL_W-1:0] pick_cost();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return dvr_pkg::VAL_W'($urandom_range(1, 15));
      3: return dvr_pkg::VAL_W'($urandom_range(255));
      4: return 16'hffff - dvr_pkg::VAL_W'($urandom_range(255));
      default: return dvr_pkg::VAL_W'($urandom);
    endcase
  endfunction

  // Present one beat, holding it until accepted; idle beforehand at random.
  task automatic send_item(dvr_pkg::kind_e k, int a, int b, int d,
                           logic [dvr_pkg::VAL_W-1:0] c, int h);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    node_a     <= dvr_pkg::NODE_W'(a);
    node_b     <= dvr_pkg::NODE_W'(b);
    dest_node  <= dvr_pkg::NODE_W'(d);
    cost_value <= c;
    hop_value  <= dvr_pkg::HOP_W'(h);
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  initial begin
    int n_act;
    int reps;
    int sel;
    in_valid   = 1'b0;
    kind       = '0;
    node_a     = '0;
    node_b     = '0;
    dest_node  = '0;
    cost_value = '0;
    hop_value  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reads of the reset state, zero and infinite links, a single improvement.
    send_item(dvr_pkg::KIND_READ, 0, 0, 0, '0, 0);
    send_item(dvr_pkg::KIND_READ, 7, 7, 7, 16'h1234, 7);
    send_item(dvr_pkg::KIND_LINK, 0, 1, 0, '0, 0);
    send_item(dvr_pkg::KIND_LINK, 1, 0, 0, '1, 0);
    send_item(dvr_pkg::KIND_ROUTE, 1, 0, 5, '0, 7);
    send_item(dvr_pkg::KIND_XCHG, 0, 1, 0, '0, 0);
    send_item(dvr_pkg::KIND_XCHG, 1, 0, 0, '0, 0);
    send_item(dvr_pkg::KIND_READ, 0, 0, 5, '0, 0);
    // Sum overflow saturates to unreachable and improves nothing.
    send_item(dvr_pkg::KIND_ROUTE, 2, 0, 3, 16'hfff0, 2);
    send_item(dvr_pkg::KIND_LINK, 4, 2, 0, 16'h0020, 0);
    send_item(dvr_pkg::KIND_XCHG, 4, 2, 0, '0, 0);
    send_item(dvr_pkg::KIND_READ, 4, 0, 3, '0, 0);
    // Improve every destination in one exchange.
    for (int x = 0; x < dvr_pkg::NODES_DEF; x++) begin
      send_item(dvr_pkg::KIND_ROUTE, 5, $urandom_range(7), x, dvr_pkg::VAL_W'(x * 3),
                $urandom_range(7));
    end
    send_item(dvr_pkg::KIND_LINK, 6, 5, 0, 16'h0001, 0);
    send_item(dvr_pkg::KIND_XCHG, 6, 5, 0, '0, 0);
    // Exchange of a node with itself.
    send_item(dvr_pkg::KIND_LINK, 5, 5, 0, 16'h0002, 0);
    send_item(dvr_pkg::KIND_XCHG, 5, 5, 0, '0, 0);
    send_item(dvr_pkg::KIND_READ, 6, 0, 7, '0, 0);

    while (items_sent < ITEM_TARGET) begin
      case ((items_sent / PHASE_ITEMS) % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 86; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 86; end
        default: begin send_idle_pct = 32; stall_pct <= 32; end
      endcase
      if ($urandom_range(9) < 8) begin
        // A small network: seed routes, load links, relax, then read back.
        n_act = $urandom_range(2, dvr_pkg::NODES_DEF);
        for (int i = 0; i < n_act; i++) begin
          sel = $urandom_range(3);
          if (sel == 0) begin
            for (int x = 0; x < n_act; x++) begin
              send_item(dvr_pkg::KIND_ROUTE, i, $urandom_range(7), x,
                        (x == i) ? '0 : '1, i);
            end
          end else if (sel == 1) begin
            send_item(dvr_pkg::KIND_ROUTE, i, $urandom_range(7), i, '0, i);
          end
        end
        reps = $urandom_range(3, 10);
        repeat (reps) begin
          send_item(dvr_pkg::KIND_LINK, $urandom_range(n_act - 1),
                    $urandom_range(n_act - 1), $urandom_range(7),
                    ($urandom_range(3) == 0) ? pick_cost() :
                                               dvr_pkg::VAL_W'($urandom_range(1, 40)),
                    $urandom_range(7));
        end
        reps = $urandom_range(4, 14);
        repeat (reps) begin
          send_item(dvr_pkg::KIND_XCHG, $urandom_range(n_act - 1),
                    $urandom_range(n_act - 1), $urandom_range(7),
                    dvr_pkg::VAL_W'($urandom), $urandom_range(7));
        end
        reps = $urandom_range(2, 6);
        repeat (reps) begin
          send_item(dvr_pkg::KIND_READ, $urandom_range(n_act - 1), $urandom_range(7),
                    $urandom_range(n_act - 1), dvr_pkg::VAL_W'($urandom),
                    $urandom_range(7));
        end
      end else begin
        reps = $urandom_range(4, 16);
        repeat (reps) begin
          send_item(dvr_pkg::kind_e'($urandom_range(3)), $urandom_range(7),
                    $urandom_range(7), $urandom_range(7), pick_cost(),
                    $urandom_range(7));
        end
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("distance_vector_relax regression: pass");
    end else begin
      $display("distance_vector_relax regression: fail");
    end
    $finish;
  end

endmodule
